// ----- rtl/vqncs_pkg.sv -----
package vqncs_pkg;

	// Default sizes of the block.
	localparam int MAX_DIM_DEF     = 16;
	localparam int MAX_CODES_DEF   = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int OP_W       = 1;
	localparam int CODE_IN_W  = 8;
	localparam int ELEM_IN_W  = 4;
	localparam int IDX_W      = 8;
	localparam int DIST_W     = 36;
	localparam int DIM_REG_W  = 5;
	localparam int SIZE_REG_W = 9;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_SEL_W  = 1;

	localparam logic [REG_SEL_W-1:0] REG_DIM  = 1'b0;
	localparam logic [REG_SEL_W-1:0] REG_SIZE = 1'b1;

	// Opcodes of an input beat.
	localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // input beat taken this cycle
		logic issue;       // read one element pair of the search
		logic first_elem;  // issued element opens a codeword
		logic last_elem;   // issued element closes a codeword
		logic first_code;  // issued element belongs to codeword zero
		logic publish;     // load the result register
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;        // elements still in the distance pipeline
		logic out_free;    // result register can take a new result
	} dp_status_t;

endpackage

// ----- rtl/vqncs_ram.sv -----
module vqncs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/vqncs_ctrl.sv -----
module vqncs_ctrl #(
	parameter int MAX_DIM   = vqncs_pkg::MAX_DIM_DEF,
	parameter int MAX_CODES = vqncs_pkg::MAX_CODES_DEF,
	localparam int CODE_W   = $clog2(MAX_CODES),
	localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [vqncs_pkg::OP_W-1:0]          opcode,
	input  logic [vqncs_pkg::ELEM_IN_W-1:0]     element_index,
	input  logic [vqncs_pkg::DIM_REG_W-1:0]     cfg_dim,
	input  logic [vqncs_pkg::SIZE_REG_W-1:0]    cfg_size,
	input  vqncs_pkg::dp_status_t               status,
	output vqncs_pkg::ctl_cmd_t                 cmd,
	output logic [CODE_W-1:0]                   code,
	output logic [DIM_W-1:0]                    elem
);

	localparam int DIMC_W  = $clog2(MAX_DIM + 1);
	localparam int CODEC_W = $clog2(MAX_CODES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;

	logic [1:0]         state_q;
	logic [CODE_W-1:0]  code_q;
	logic [DIM_W-1:0]   elem_q;
	logic [DIMC_W-1:0]  dim_eff;
	logic [CODEC_W-1:0] codes_eff;
	logic               accept;
	logic               start;
	logic               last_elem;
	logic               last_code;

	// Out-of-range register values are clamped into the supported range.
	always_comb begin
		if (cfg_dim == '0) begin
			dim_eff = DIMC_W'(1);
		end else if (int'(cfg_dim) > MAX_DIM) begin
			dim_eff = DIMC_W'(MAX_DIM);
		end else begin
			dim_eff = DIMC_W'(cfg_dim);
		end
		if (cfg_size == '0) begin
			codes_eff = CODEC_W'(1);
		end else if (int'(cfg_size) > MAX_CODES) begin
			codes_eff = CODEC_W'(MAX_CODES);
		end else begin
			codes_eff = CODEC_W'(cfg_size);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign start     = accept && (opcode == vqncs_pkg::OP_SAMPLE) &&
		(int'(element_index) == int'(dim_eff) - 1);
	assign last_elem = (elem_q == DIM_W'(dim_eff - 1'b1));
	assign last_code = (code_q == CODE_W'(codes_eff - 1'b1));

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.issue      = (state_q == ST_SEARCH);
		cmd.first_elem = (elem_q == '0);
		cmd.last_elem  = last_elem;
		cmd.first_code = (code_q == '0);
		cmd.publish    = (state_q == ST_DRAIN) && !status.busy && status.out_free;
	end

	assign code = code_q;
	assign elem = elem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= '0;
			elem_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						code_q  <= '0;
						elem_q  <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (last_elem) begin
						elem_q <= '0;
						if (last_code) begin
							state_q <= ST_DRAIN;
						end else begin
							code_q <= code_q + 1'b1;
						end
					end else begin
						elem_q <= elem_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cmd.publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/vqncs_dp.sv -----
module vqncs_dp #(
	parameter int MAX_DIM     = vqncs_pkg::MAX_DIM_DEF,
	parameter int MAX_CODES   = vqncs_pkg::MAX_CODES_DEF,
	parameter int SAMPLE_BITS = vqncs_pkg::SAMPLE_BITS_DEF,
	localparam int CODE_W     = $clog2(MAX_CODES),
	localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vqncs_pkg::ctl_cmd_t                  cmd,
	output vqncs_pkg::dp_status_t                status,
	input  logic [CODE_W-1:0]                    code,
	input  logic [DIM_W-1:0]                     elem,
	input  logic [vqncs_pkg::OP_W-1:0]           opcode,
	input  logic [vqncs_pkg::CODE_IN_W-1:0]      code_index,
	input  logic [vqncs_pkg::ELEM_IN_W-1:0]      element_index,
	input  logic signed [SAMPLE_BITS-1:0]        value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [vqncs_pkg::IDX_W-1:0]          best_index,
	output logic [vqncs_pkg::DIST_W-1:0]         best_distance
);

	localparam int CIN_W  = vqncs_pkg::CODE_IN_W;
	localparam int EIN_W  = vqncs_pkg::ELEM_IN_W;
	localparam int DIST_W = vqncs_pkg::DIST_W;
	localparam int ACC_W  = 2 * SAMPLE_BITS + $clog2(MAX_DIM);
	localparam int CB_AW  = CODE_W + DIM_W;

	logic [CODE_W-1:0]      code_w;
	logic [DIM_W-1:0]       elem_w;
	logic [SAMPLE_BITS-1:0] cb_rdata;
	logic [SAMPLE_BITS-1:0] vec_rdata;

	// Incoming indexes wrap into the store. Division by the store size is done
	// with an exact reciprocal multiply, since the index is only a few bits.
	if (MAX_CODES < (1 << CIN_W)) begin : g_code_wrap
		localparam int CSH = CIN_W + CODE_W;
		localparam int CPW = CIN_W + CSH + 1;
		localparam logic [CPW-1:0] CRCP =
			CPW'(((64'd1 << CSH) + 64'(MAX_CODES) - 64'd1) / 64'(MAX_CODES));
		logic [CPW-1:0]   cprod;
		logic [CIN_W-1:0] cquo;
		logic [CIN_W-1:0] crem;
		always_comb begin
			cprod  = CPW'(code_index) * CRCP;
			cquo   = CIN_W'(cprod >> CSH);
			crem   = code_index - CIN_W'(cquo * CIN_W'(MAX_CODES));
			code_w = CODE_W'(crem);
		end
	end else begin : g_code_direct
		assign code_w = CODE_W'(code_index);
	end

	if (MAX_DIM < (1 << EIN_W)) begin : g_elem_wrap
		localparam int ESH = EIN_W + DIM_W;
		localparam int EPW = EIN_W + ESH + 1;
		localparam logic [EPW-1:0] ERCP =
			EPW'(((64'd1 << ESH) + 64'(MAX_DIM) - 64'd1) / 64'(MAX_DIM));
		logic [EPW-1:0]   eprod;
		logic [EIN_W-1:0] equo;
		logic [EIN_W-1:0] erem;
		always_comb begin
			eprod  = EPW'(element_index) * ERCP;
			equo   = EIN_W'(eprod >> ESH);
			erem   = element_index - EIN_W'(equo * EIN_W'(MAX_DIM));
			elem_w = DIM_W'(erem);
		end
	end else begin : g_elem_direct
		assign elem_w = DIM_W'(element_index);
	end

	vqncs_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (1 << CB_AW)
	) u_codebook (
		.clk   (clk),
		.we    (cmd.accept && (opcode == vqncs_pkg::OP_LOAD)),
		.waddr ({code_w, elem_w}),
		.wdata (value),
		.raddr ({code, elem}),
		.rdata (cb_rdata)
	);

	vqncs_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (1 << DIM_W)
	) u_vector (
		.clk   (clk),
		.we    (cmd.accept && (opcode == vqncs_pkg::OP_SAMPLE)),
		.waddr (elem_w),
		.wdata (value),
		.raddr (elem),
		.rdata (vec_rdata)
	);

	// Distance pipeline: read, absolute difference, square, accumulate, compare.
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic                   first_s1, first_s2, first_s3;
	logic                   last_s1, last_s2, last_s3, last_s4;
	logic                   fcode_s1, fcode_s2, fcode_s3, fcode_s4;
	logic [CODE_W-1:0]      code_s1, code_s2, code_s3, code_s4;
	logic [SAMPLE_BITS-1:0] ad_s2;
	logic [2*SAMPLE_BITS-1:0] sq_s3;
	logic [ACC_W-1:0]       acc_q;
	logic [ACC_W-1:0]       best_d_q;
	logic [CODE_W-1:0]      best_c_q;
	logic signed [SAMPLE_BITS:0] diff;
	logic [SAMPLE_BITS:0]   diff_abs;
	logic [DIST_W-1:0]      dist_sat;
	logic                   out_valid_q;

	assign diff     = $signed({cb_rdata[SAMPLE_BITS-1], cb_rdata}) -
		$signed({vec_rdata[SAMPLE_BITS-1], vec_rdata});
	assign diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first_elem;
		last_s1  <= cmd.last_elem;
		fcode_s1 <= cmd.first_code;
		code_s1  <= code;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fcode_s2 <= fcode_s1;
		code_s2  <= code_s1;
		ad_s2    <= diff_abs[SAMPLE_BITS-1:0];

		first_s3 <= first_s2;
		last_s3  <= last_s2;
		fcode_s3 <= fcode_s2;
		code_s3  <= code_s2;
		sq_s3    <= ad_s2 * ad_s2;

		last_s4  <= last_s3;
		fcode_s4 <= fcode_s3;
		code_s4  <= code_s3;
		if (v_s3) begin
			acc_q <= (first_s3 ? '0 : acc_q) + ACC_W'(sq_s3);
		end

		// Strict compare keeps the lowest index on a tie.
		if (v_s4 && last_s4 && (fcode_s4 || (acc_q < best_d_q))) begin
			best_d_q <= acc_q;
			best_c_q <= code_s4;
		end
	end

	if (ACC_W > DIST_W) begin : g_sat
		assign dist_sat = (|best_d_q[ACC_W-1:DIST_W]) ? '1 : best_d_q[DIST_W-1:0];
	end else begin : g_nosat
		assign dist_sat = DIST_W'(best_d_q);
	end

	// Result register: holds the beat while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			best_index    <= vqncs_pkg::IDX_W'(best_c_q);
			best_distance <= dist_sat;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.busy     = v_s1 || v_s2 || v_s3 || v_s4;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

// ----- rtl/vq_nearest_codeword_search.sv -----
// Full-search vector quantizer encoder.
// Input channel (in_valid/in_stall): a load beat (opcode 0) writes one element
// of one codeword into the codebook memory; a sample beat (opcode 1) writes one
// element of the input vector. The sample beat whose element_index equals
// dimension_in_use-1 starts a search over codewords 0..codebook_size-1.
// Load beats and other sample beats are taken whenever in_stall is low.
// A search reads one codeword element per cycle from a single memory port;
// it then waits for the distance pipeline to empty and for the result
// register to be free, and loads it. in_stall is high for that whole time.
// Output channel (out_valid/out_stall): best_index and best_distance of the
// nearest codeword, lowest index on a tie. The result register holds its beat
// while out_stall is high; input beats that start no search are still taken,
// and a new search finishes only once the previous result has been taken.
// Registers over the APB port: dimension_in_use at 0x0, codebook_size at 0x4.
// Reset returns both registers to 1 and empties the pipeline; codebook and
// vector contents are undefined until written.
module vq_nearest_codeword_search #(
	parameter int MAX_DIM     = vqncs_pkg::MAX_DIM_DEF,
	parameter int MAX_CODES   = vqncs_pkg::MAX_CODES_DEF,
	parameter int SAMPLE_BITS = vqncs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [vqncs_pkg::OP_W-1:0]            opcode,
	input  logic [vqncs_pkg::CODE_IN_W-1:0]       code_index,
	input  logic [vqncs_pkg::ELEM_IN_W-1:0]       element_index,
	input  logic signed [SAMPLE_BITS-1:0]         value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [vqncs_pkg::IDX_W-1:0]           best_index,
	output logic [vqncs_pkg::DIST_W-1:0]          best_distance,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [vqncs_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [vqncs_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [vqncs_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                  pready
);

	localparam int CODE_W = $clog2(MAX_CODES);
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DREG_W = vqncs_pkg::DIM_REG_W;
	localparam int SREG_W = vqncs_pkg::SIZE_REG_W;
	localparam int DATA_W = vqncs_pkg::APB_DATA_W;

	logic [DREG_W-1:0]                  dim_q;
	logic [SREG_W-1:0]                  size_q;
	logic [vqncs_pkg::REG_SEL_W-1:0]    reg_sel;
	logic                               reg_wr;
	vqncs_pkg::ctl_cmd_t                cmd;
	vqncs_pkg::dp_status_t              status;
	logic [CODE_W-1:0]                  code;
	logic [DIM_W-1:0]                   elem;

	assign pready  = 1'b1;
	assign reg_sel = paddr[vqncs_pkg::APB_ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= DREG_W'(1);
			size_q <= SREG_W'(1);
		end else if (reg_wr) begin
			unique case (reg_sel)
				vqncs_pkg::REG_DIM:  dim_q  <= pwdata[DREG_W-1:0];
				vqncs_pkg::REG_SIZE: size_q <= pwdata[SREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			vqncs_pkg::REG_DIM:  prdata = DATA_W'(dim_q);
			vqncs_pkg::REG_SIZE: prdata = DATA_W'(size_q);
			default:             prdata = '0;
		endcase
	end

	vqncs_ctrl #(
		.MAX_DIM   (MAX_DIM),
		.MAX_CODES (MAX_CODES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.element_index (element_index),
		.cfg_dim       (dim_q),
		.cfg_size      (size_q),
		.status        (status),
		.cmd           (cmd),
		.code          (code),
		.elem          (elem)
	);

	vqncs_dp #(
		.MAX_DIM     (MAX_DIM),
		.MAX_CODES   (MAX_CODES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.code          (code),
		.elem          (elem),
		.opcode        (opcode),
		.code_index    (code_index),
		.element_index (element_index),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.best_index    (best_index),
		.best_distance (best_distance)
	);

endmodule
